// ===== rtl/core/fifo_queue_with_search_assert.svh =====
// Assertion macros for the queue-with-search block.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define FQS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("queue checker: same-cycle property failed");

// Whenever the antecedent holds, the consequent holds in the following cycle.
`define FQS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("queue checker: next-cycle property failed");

`endif

// ===== rtl/core/fqs_pkg.sv =====
// Shared types and constants of the queue-with-search block.
// No dependencies; used by the top level and the port checker.
package fqs_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 5;

    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_SEARCH  = 2'd2,
        MODE_DISPLAY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

endpackage

// ===== rtl/core/fifo_queue_with_search.sv =====
// Top level of the bounded FIFO queue with linear search and display.
// Depends on fqs_pkg and fqs_ram.
//
//  Channel  | Direction | tdata (low bit up)                    | tuser        | tlast
//  ---------+-----------+---------------------------------------+--------------+-------------
//  s_axis   | in        | value[31:0]                           | mode[1:0]    | -
//  m_axis   | out       | data[31:0], position[36:32], zero pad | status[1:0]  | last result
//
// Insert and any operation on an empty queue go from the transfer to ST_EMIT, which
// loads the result register; a delete reads the head at the transfer and loads it from
// ST_WALK. Display and search walk the stored entries from the single RAM read port,
// one per cycle unless a waiting result holds the walk; a search ends in ST_EMIT.
// Reset clears the head index, the occupancy and the output valid; the entry RAM is
// not cleared. A result waiting in the output register pauses the walk until taken.
module fifo_queue_with_search #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // data[31:0], position[36:32], zero[39:37]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);
    import fqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    // Control state.
    t_state  r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [OW-1:0] r_occ, n_occ;
    logic    r_out_valid, n_out_valid;

    // Working registers of the current item.
    t_mode   r_mode, n_mode;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic [OW-1:0] r_k, n_k;
    logic [AW-1:0] r_addr, n_addr;
    logic    r_hold_valid, n_hold_valid;
    t_status r_fin_status, n_fin_status;
    logic signed [DATA_W-1:0] r_fin_data, n_fin_data;
    logic [POS_W-1:0] r_fin_pos, n_fin_pos;

    // Output register payload.
    t_status r_out_status, n_out_status;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic [POS_W-1:0] r_out_pos, n_out_pos;
    logic    r_out_last, n_out_last;

    // RAM ports.
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    logic          s_acc;
    logic          can_load;
    logic          full;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] head_next;
    logic [AW-1:0] addr_next;
    logic [OW-1:0] k_plus1;
    logic [31:0]   k_plus1_ext;
    logic [POS_W-1:0] pos_cur;
    logic          last_idx;
    logic          match;
    t_mode         in_mode;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign can_load      = !r_out_valid || m_axis_tready;
    assign in_mode       = t_mode'(s_axis_tuser);

    assign full = (r_occ == OW'(DEPTH));

    // Tail slot: head plus occupancy, wrapped once around the ring.
    assign tail_sum  = (AW + 1)'(r_head) + (AW + 1)'(r_occ);
    assign tail_slot = (tail_sum >= (AW + 1)'(DEPTH)) ?
                       AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);

    assign head_next = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign addr_next = (r_addr == AW'(DEPTH - 1)) ? '0 : r_addr + AW'(1);

    assign k_plus1     = r_k + OW'(1);
    assign k_plus1_ext = 32'(k_plus1);
    assign pos_cur     = k_plus1_ext[POS_W-1:0];
    assign last_idx    = (k_plus1 == r_occ);
    assign match       = (ram_rd_data == r_key);

    assign ram_wr_addr = tail_slot;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_occ        = r_occ;
        n_mode       = r_mode;
        n_key        = r_key;
        n_k          = r_k;
        n_addr       = r_addr;
        n_hold_valid = r_hold_valid;
        n_fin_status = r_fin_status;
        n_fin_data   = r_fin_data;
        n_fin_pos    = r_fin_pos;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_pos    = r_out_pos;
        n_out_last   = r_out_last;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_head;

        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_mode       = in_mode;
                    n_key        = s_axis_tdata;
                    n_k          = '0;
                    n_addr       = r_head;
                    n_hold_valid = 1'b0;
                    n_fin_data   = '0;
                    n_fin_pos    = '0;
                    if (in_mode == MODE_INSERT) begin
                        if (full) begin
                            n_fin_status = STAT_FULL;
                        end else begin
                            ram_wr_en    = 1'b1;
                            n_occ        = r_occ + OW'(1);
                            n_fin_status = STAT_OK;
                        end
                        n_state = ST_EMIT;
                    end else if (r_occ == '0) begin
                        n_fin_status = STAT_EMPTY;
                        n_state      = ST_EMIT;
                    end else begin
                        // Delete, search and display all start with a head read.
                        ram_rd_en    = 1'b1;
                        n_fin_status = STAT_NOT_FOUND;
                        n_state      = ST_WALK;
                        if (in_mode == MODE_DELETE) begin
                            n_occ  = r_occ - OW'(1);
                            n_head = (r_occ == OW'(1)) ? '0 : head_next;
                        end
                    end
                end
            end

            ST_WALK: begin
                case (r_mode)
                    MODE_SEARCH: begin
                        // The latest match is held back so that the final one can
                        // carry the last mark.
                        if (!(match && r_hold_valid && !can_load)) begin
                            if (match && r_hold_valid) begin
                                n_out_valid  = 1'b1;
                                n_out_status = STAT_OK;
                                n_out_data   = r_fin_data;
                                n_out_pos    = r_fin_pos;
                                n_out_last   = 1'b0;
                            end
                            if (match) begin
                                n_hold_valid = 1'b1;
                                n_fin_status = STAT_OK;
                                n_fin_data   = ram_rd_data;
                                n_fin_pos    = pos_cur;
                            end
                            if (last_idx) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_k         = k_plus1;
                                n_addr      = addr_next;
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = addr_next;
                            end
                        end
                    end
                    MODE_DISPLAY: begin
                        if (can_load) begin
                            n_out_valid  = 1'b1;
                            n_out_status = STAT_OK;
                            n_out_data   = ram_rd_data;
                            n_out_pos    = pos_cur;
                            n_out_last   = last_idx;
                            if (last_idx) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_k         = k_plus1;
                                n_addr      = addr_next;
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = addr_next;
                            end
                        end
                    end
                    default: begin
                        // Delete: the popped head entry is in the read data.
                        if (can_load) begin
                            n_out_valid  = 1'b1;
                            n_out_status = STAT_OK;
                            n_out_data   = ram_rd_data;
                            n_out_pos    = '0;
                            n_out_last   = 1'b1;
                            n_state      = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_EMIT: begin
                if (can_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_fin_status;
                    n_out_data   = r_fin_data;
                    n_out_pos    = r_fin_pos;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_k          <= n_k;
        r_addr       <= n_addr;
        r_hold_valid <= n_hold_valid;
        r_fin_status <= n_fin_status;
        r_fin_data   <= n_fin_data;
        r_fin_pos    <= n_fin_pos;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_pos    <= n_out_pos;
        r_out_last   <= n_out_last;
    end

    fqs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_pos, r_out_data};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/core/fqs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // Read data holds until the next read is issued.
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/fqs_checker.sv =====
// Port-level checker of the queue-with-search block, bound to its top level.
// Depends on fqs_pkg and fifo_queue_with_search_assert.svh.
`include "fifo_queue_with_search_assert.svh"

module fqs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import fqs_pkg::*;

    logic s_acc;
    logic m_err;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_err = m_axis_tvalid && (m_axis_tuser != STAT_OK);

    // Every error result stands alone, so it always ends its run.
    `FQS_ASSERT_NOW(a_err_is_last, m_err, m_axis_tlast)
    // Error results carry neither data nor position.
    `FQS_ASSERT_NOW(a_err_no_payload, m_err, m_axis_tdata[36:0] == 37'd0)
    // One item is worked on at a time: a transfer in closes the input side.
    `FQS_ASSERT_NEXT(a_one_item, s_acc, !s_axis_tready)
    // A stalled result stays in place.
    `FQS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/fqs_result_checker.sv =====
// Scoreboard for the queue-with-search block: watches both stream channels,
// mirrors the queue contents and compares every result transfer field by field.
// Depends on fqs_pkg for the mode and status codes.
module fqs_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // data[31:0], position[36:32], zero[39:37]
    input  logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_results_owed
);
    import fqs_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [31:0] data;
        logic [4:0]  position;
        logic        last;
    } t_queue_result;

    t_queue_result queue_results_owed[$];
    logic [31:0]   mirror_store [DEPTH];
    int            mirror_head;
    int            mirror_fill;
    int            fail_total;

    assign o_fail_count = fail_total;

    function automatic t_queue_result make_result(t_status status, logic [31:0] data,
                                                  logic [4:0] position, logic last);
        t_queue_result r;
        r.status   = status;
        r.data     = data;
        r.position = position;
        r.last     = last;
        return r;
    endfunction

    // Apply one operation to the mirrored queue and queue up what it must produce.
    function void mirror_queue_op(t_mode mode, logic [31:0] value);
        int k;
        int hits;
        int seen;
        logic [31:0] entry;
        if (mode == MODE_INSERT) begin
            if (mirror_fill >= DEPTH) begin
                queue_results_owed.push_back(make_result(STAT_FULL, '0, '0, 1'b1));
            end else begin
                mirror_store[(mirror_head + mirror_fill) % DEPTH] = value;
                mirror_fill++;
                queue_results_owed.push_back(make_result(STAT_OK, '0, '0, 1'b1));
            end
        end else if (mirror_fill == 0) begin
            queue_results_owed.push_back(make_result(STAT_EMPTY, '0, '0, 1'b1));
        end else if (mode == MODE_DELETE) begin
            entry = mirror_store[mirror_head];
            mirror_head = (mirror_head + 1) % DEPTH;
            mirror_fill--;
            // An emptied queue starts over from the first slot.
            if (mirror_fill == 0) begin
                mirror_head = 0;
            end
            queue_results_owed.push_back(make_result(STAT_OK, entry, '0, 1'b1));
        end else if (mode == MODE_SEARCH) begin
            hits = 0;
            for (k = 0; k < mirror_fill; k++) begin
                if (mirror_store[(mirror_head + k) % DEPTH] == value) begin
                    hits++;
                end
            end
            if (hits == 0) begin
                queue_results_owed.push_back(make_result(STAT_NOT_FOUND, '0, '0, 1'b1));
            end else begin
                seen = 0;
                for (k = 0; k < mirror_fill; k++) begin
                    entry = mirror_store[(mirror_head + k) % DEPTH];
                    if (entry == value) begin
                        seen++;
                        queue_results_owed.push_back(make_result(STAT_OK, entry,
                            5'(k + 1), seen == hits));
                    end
                end
            end
        end else begin
            for (k = 0; k < mirror_fill; k++) begin
                queue_results_owed.push_back(make_result(STAT_OK,
                    mirror_store[(mirror_head + k) % DEPTH], 5'(k + 1),
                    k == mirror_fill - 1));
            end
        end
    endfunction

    function void note_failure(string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        t_queue_result owed;
        t_queue_result got;
        if (!i_rst_n) begin
            mirror_head = 0;
            mirror_fill = 0;
            fail_total  = 0;
            queue_results_owed.delete();
        end else begin
            // Results are checked before new work is predicted: a result can never
            // come from an operation accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got = make_result(t_status'(m_axis_tuser), m_axis_tdata[31:0],
                                  m_axis_tdata[36:32], m_axis_tlast);
                if (queue_results_owed.size() == 0) begin
                    note_failure($sformatf("unexpected result status=%0d data=%h pos=%0d last=%b",
                        got.status, got.data, got.position, got.last));
                end else begin
                    owed = queue_results_owed.pop_front();
                    if (got.status !== owed.status || got.data !== owed.data ||
                        got.position !== owed.position || got.last !== owed.last ||
                        m_axis_tdata[39:37] !== 3'b000) begin
                        note_failure({
                            $sformatf("expected status=%0d data=%h pos=%0d last=%b, ",
                                owed.status, owed.data, owed.position, owed.last),
                            $sformatf("got status=%0d data=%h pos=%0d last=%b pad=%b",
                                got.status, got.data, got.position, got.last,
                                m_axis_tdata[39:37])});
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                mirror_queue_op(t_mode'(s_axis_tuser), s_axis_tdata);
            end
        end
        o_results_owed <= queue_results_owed.size();
    end

endmodule

// ===== tb/tb_fifo_queue_with_search.sv =====
// Testbench top for the queue-with-search block: clock, reset, operation
// stimulus and random back-pressure. Depends on fqs_pkg, the block itself
// and fqs_result_checker, which does all of the prediction and comparison.
module tb_fifo_queue_with_search;
    import fqs_pkg::*;

    localparam int DEPTH = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // value[31:0]
    logic [1:0]  s_axis_tuser;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // data[31:0], position[36:32], zero[39:37]
    logic [1:0]  m_axis_tuser;   // status[1:0]
    logic        m_axis_tlast;

    int fail_count;
    int results_owed;

    // Idle-free stretches for each side, counted in transfers.
    int send_calm;
    int take_calm;

    fifo_queue_with_search #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    fqs_result_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_results_owed(results_owed)
    );

    // 20 time unit clock period.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Hard stop in case a handshake never completes. The slowest correct run
    // (every display returning sixteen results, each behind a long stall) stays
    // well inside this.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Gap length in cycles: mostly none or short, now and then long. Every so
    // often a stretch of back-to-back transfers is started so that the block also
    // sees full-rate traffic.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 24);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 20);
    endfunction

    // Values are mostly drawn from a small pool so that searches find matches,
    // including repeated ones; the rest are fully random to toggle every bit.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                3: return 32'h7FFF_FFFF;
                4: return 32'h0000_0005;
                default: return 32'h0000_002A;
            endcase
        end
        return $urandom();
    endfunction

    // One operation transfer on the input channel. Inputs only change at the
    // falling edge, and tvalid is left high after the transfer so that a
    // following transfer with no gap keeps it high without a glitch.
    task automatic send_op(input t_mode mode, input logic [31:0] value);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Output side: alternate runs of tready high with stalls of random length,
    // so that stalls land on every step of a search or display walk.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        take_calm     = 0;
        forever begin
            @(negedge i_clk);
            stall = pick_gap(take_calm);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
        end
    end

    initial begin
        int i;
        int r;
        int phase;
        t_mode mode;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_INSERT;
        send_calm     = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part. Delete, search and display on the empty queue first.
        send_op(MODE_DELETE, 32'h0000_0000);
        send_op(MODE_SEARCH, 32'h0000_0000);
        send_op(MODE_DISPLAY, 32'hFFFF_FFFF);

        // Extremes of the value field, with a repeated key for a multi-hit search.
        send_op(MODE_INSERT, 32'h7FFF_FFFF);
        send_op(MODE_INSERT, 32'h8000_0000);
        send_op(MODE_INSERT, 32'h0000_0000);
        send_op(MODE_INSERT, 32'hFFFF_FFFF);
        send_op(MODE_INSERT, 32'h7FFF_FFFF);
        send_op(MODE_SEARCH, 32'h7FFF_FFFF);
        send_op(MODE_SEARCH, 32'h0001_2345);
        send_op(MODE_DISPLAY, 32'h0000_0000);
        send_op(MODE_DELETE, 32'h5555_5555);

        // Fill to capacity so the ring wraps, push once more to hit the full
        // case, then walk the whole queue and search for a key held twice.
        for (i = 0; i < DEPTH - 4; i++) begin
            send_op(MODE_INSERT, (i == 6) ? 32'hFFFF_FFFF : (32'hA5A5_0000 | i));
        end
        send_op(MODE_INSERT, 32'h1234_5678);
        send_op(MODE_DISPLAY, 32'h0000_0000);
        send_op(MODE_SEARCH, 32'hFFFF_FFFF);

        // Random part, in phases that lean toward filling, draining or a mix, so
        // the queue keeps crossing both the full and the empty boundary.
        phase = 0;
        for (i = 0; i < 84; i++) begin
            if (i % 22 == 0) begin
                phase = $urandom_range(0, 2);
            end
            r = $urandom_range(0, 99);
            case (phase)
                0: mode = (r < 70) ? MODE_INSERT : (r < 80) ? MODE_DELETE :
                          (r < 92) ? MODE_SEARCH : MODE_DISPLAY;
                1: mode = (r < 15) ? MODE_INSERT : (r < 80) ? MODE_DELETE :
                          (r < 90) ? MODE_SEARCH : MODE_DISPLAY;
                default: mode = (r < 40) ? MODE_INSERT : (r < 70) ? MODE_DELETE :
                                (r < 85) ? MODE_SEARCH : MODE_DISPLAY;
            endcase
            if (mode == MODE_INSERT || mode == MODE_SEARCH) begin
                send_op(mode, pick_value());
            end else begin
                // The value is ignored here, but still toggled.
                send_op(mode, $urandom());
            end
        end
        s_axis_tvalid = 1'b0;

        // Drain: wait until every predicted result has been taken, then go on waiting
        // so that any stray result from the block still shows.
        while (results_owed != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (fail_count == 0 && results_owed == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
